### rtl/ctpg_pkg.sv
package ctpg_pkg;

  // default geometry
  localparam int FRAC_BITS_DEF  = 3;
  localparam int COORD_BITS_DEF = 10;

  // fixed field widths
  localparam int OUT_W    = 12;
  localparam int COLOUR_W = 4;

  // register port
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // register reset values
  localparam int RST_CENTER_X   = 320;
  localparam int RST_CENTER_Y   = 240;
  localparam int RST_RADIUS     = 200;
  localparam int RST_START_X    = 320;
  localparam int RST_START_Y    = 40;
  localparam int RST_PEN_COLOUR = 14;

  // register map, index = byte address / 4
  typedef enum logic [2:0] {
    REG_CENTER_X,
    REG_CENTER_Y,
    REG_RADIUS,
    REG_START_X,
    REG_START_Y,
    REG_PEN_COLOUR
  } reg_idx_e;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SQ_R,
    S_SQ_D,
    S_ROOT,
    S_CHECK,
    S_DONE
  } state_e;

  // trace segments
  typedef enum logic [2:0] {
    SEG_TO_CENTER,
    SEG_TO_BOTTOM,
    SEG_BACK_CENTER,
    SEG_TO_TOP,
    SEG_TO_START
  } seg_e;

endpackage

### rtl/ctpg_cfg_regs.sv
module ctpg_cfg_regs #(
  parameter int COORD_BITS = ctpg_pkg::COORD_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ctpg_pkg::ADDR_W-1:0]   paddr,
  input  logic [ctpg_pkg::DATA_W-1:0]   pwdata,
  output logic [ctpg_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output logic [COORD_BITS-1:0]         center_x_o,
  output logic [COORD_BITS-1:0]         center_y_o,
  output logic [COORD_BITS-1:0]         radius_o,
  output logic [COORD_BITS-1:0]         start_x_o,
  output logic [COORD_BITS-1:0]         start_y_o,
  output logic [ctpg_pkg::COLOUR_W-1:0] pen_colour_o
);
  import ctpg_pkg::*;

  logic [COORD_BITS-1:0] center_x_q, center_y_q, radius_q, start_x_q, start_y_q;
  logic [COLOUR_W-1:0]   pen_colour_q;
  logic                  wr_en;
  reg_idx_e              idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[ADDR_W-1:2]);

  // register writes; out-of-map indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q   <= COORD_BITS'(RST_CENTER_X);
      center_y_q   <= COORD_BITS'(RST_CENTER_Y);
      radius_q     <= COORD_BITS'(RST_RADIUS);
      start_x_q    <= COORD_BITS'(RST_START_X);
      start_y_q    <= COORD_BITS'(RST_START_Y);
      pen_colour_q <= COLOUR_W'(RST_PEN_COLOUR);
    end else if (wr_en) begin
      case (idx)
        REG_CENTER_X:   center_x_q   <= pwdata[COORD_BITS-1:0];
        REG_CENTER_Y:   center_y_q   <= pwdata[COORD_BITS-1:0];
        REG_RADIUS:     radius_q     <= pwdata[COORD_BITS-1:0];
        REG_START_X:    start_x_q    <= pwdata[COORD_BITS-1:0];
        REG_START_Y:    start_y_q    <= pwdata[COORD_BITS-1:0];
        REG_PEN_COLOUR: pen_colour_q <= pwdata[COLOUR_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (idx)
      REG_CENTER_X:   prdata = DATA_W'(center_x_q);
      REG_CENTER_Y:   prdata = DATA_W'(center_y_q);
      REG_RADIUS:     prdata = DATA_W'(radius_q);
      REG_START_X:    prdata = DATA_W'(start_x_q);
      REG_START_Y:    prdata = DATA_W'(start_y_q);
      REG_PEN_COLOUR: prdata = DATA_W'(pen_colour_q);
      default:        prdata = '0;
    endcase
  end

  assign center_x_o   = center_x_q;
  assign center_y_o   = center_y_q;
  assign radius_o     = radius_q;
  assign start_x_o    = start_x_q;
  assign start_y_o    = start_y_q;
  assign pen_colour_o = pen_colour_q;

endmodule

### rtl/ctpg_isqrt.sv
module ctpg_isqrt #(
  parameter int RW = ctpg_pkg::COORD_BITS_DEF + ctpg_pkg::FRAC_BITS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [2*RW-1:0] radicand_i,
  output logic            done_o,
  output logic [RW-1:0]   root_o
);
  import ctpg_pkg::*;

  localparam int CNT_W = $clog2(RW + 1);

  logic [2*RW-1:0]  rad_q;
  logic [RW+1:0]    rem_q;
  logic [RW-1:0]    root_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [RW+2:0]    rem_n, trial, diff;
  logic             ge;

  // one root bit per cycle: bring down two radicand bits, try 4*root+1
  assign rem_n = {rem_q[RW:0], rad_q[2*RW-1 -: 2]};
  assign trial = (RW+3)'({root_q, 2'b01});
  assign ge    = rem_n >= trial;
  assign diff  = rem_n - trial;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(RW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q <= rad_q << 2;
      if (ge) begin
        rem_q  <= diff[RW+1:0];
        root_q <= {root_q[RW-2:0], 1'b1};
      end else begin
        rem_q  <= rem_n[RW+1:0];
        root_q <= {root_q[RW-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

### rtl/circle_trace_point_generator.sv
// While a trace runs, a step word taken in S_IDLE passes through S_SQ_R, S_SQ_D, S_ROOT
// (the bit-serial square root, one root bit per cycle), S_CHECK and S_DONE; its pixel word
// is loaded into the output register from S_DONE once that register is free. A step with
// no trace running goes from S_IDLE straight to S_DONE and gives an idle word. No new step
// word is taken until the previous one's word has been loaded into the output register.
// Reset: asynchronous, active low; registers take their reset values, no trace runs,
// no memory, no clearing pass.
module circle_trace_point_generator #(
  parameter int FRAC_BITS  = ctpg_pkg::FRAC_BITS_DEF,
  parameter int COORD_BITS = ctpg_pkg::COORD_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ctpg_pkg::ADDR_W-1:0]   paddr,
  input  logic [ctpg_pkg::DATA_W-1:0]   pwdata,
  output logic [ctpg_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  // step words
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          restart_i,
  // pixel words
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [ctpg_pkg::OUT_W-1:0]    pixel_x_o,
  output logic [ctpg_pkg::OUT_W-1:0]    pixel_y_o,
  output logic [ctpg_pkg::COLOUR_W-1:0] colour_o,
  output logic                          last_o,
  output logic                          idle_o
);
  import ctpg_pkg::*;

  localparam int RW    = COORD_BITS + FRAC_BITS;  // root width
  localparam int CW    = 2 * RW;                  // radicand width
  localparam int ROW_W = RW + 2;                  // signed sweep row
  localparam int DY_W  = RW + 3;                  // signed row offset
  localparam int OPW   = RW + 1;                  // multiplier operand
  localparam int PW    = 2 * OPW;                 // product
  localparam int XW    = COORD_BITS + OUT_W;      // wide column math

  // configuration
  logic [COORD_BITS-1:0] center_x, center_y, radius, start_x, start_y;
  logic [COLOUR_W-1:0]   pen_colour;

  ctpg_cfg_regs #(.COORD_BITS(COORD_BITS)) u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .center_x_o(center_x), .center_y_o(center_y), .radius_o(radius),
    .start_x_o(start_x), .start_y_o(start_y), .pen_colour_o(pen_colour)
  );

  // state
  state_e                  state_q, state_d;
  logic                    active_q, active_d;
  seg_e                    seg_q, seg_d;
  logic signed [ROW_W-1:0] row_q, row_d;
  logic [CW-1:0]           rs2_q, c_q;
  logic [RW-1:0]           root_q;
  logic [OUT_W-1:0]        res_x_q, res_y_q;
  logic                    res_last_q, res_idle_q;
  logic                    out_valid_q;
  logic [OUT_W-1:0]        pixel_x_q, pixel_y_q;
  logic [COLOUR_W-1:0]     colour_q;
  logic                    last_q, idle_q;

  logic in_acc, out_free, quad;
  logic sq_done;
  logic [RW-1:0] sq_root;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // start point inside the upper-right quadrant
  assign quad = (start_x >= center_x)
             && ({1'b0, start_x} < ({1'b0, center_x} + {1'b0, radius}))
             && (({1'b0, start_y} + {1'b0, radius}) >= {1'b0, center_y})
             && (start_y < center_y);

  // rows in sub-pixel units
  logic signed [ROW_W-1:0] k_s, kpr_s, kmr_s, sy_s;
  assign k_s   = $signed(ROW_W'(center_y)) <<< FRAC_BITS;
  assign kpr_s = ($signed(ROW_W'(center_y)) + $signed(ROW_W'(radius))) <<< FRAC_BITS;
  assign kmr_s = ($signed(ROW_W'(center_y)) - $signed(ROW_W'(radius))) <<< FRAC_BITS;
  assign sy_s  = $signed(ROW_W'(start_y)) <<< FRAC_BITS;

  // row offset from the center row, as a magnitude
  logic signed [DY_W-1:0] dy;
  logic [DY_W-1:0]        dy_abs;
  assign dy     = DY_W'(row_q) - DY_W'(k_s);
  assign dy_abs = dy[DY_W-1] ? DY_W'(-dy) : DY_W'(dy);

  // shared squarer: r*S, then dy, then the floored root for the exactness check
  logic [RW-1:0]  f_c;      // floor(d), root with fraction dropped
  logic [RW-1:0]  f_s;      // f shifted back to sub-pixel units
  logic [OPW-1:0] mul_a;
  logic [PW-1:0]  mul_p;
  assign f_c = root_q >> FRAC_BITS;
  assign f_s = f_c << FRAC_BITS;

  always_comb begin
    case (state_q)
      S_SQ_R:  mul_a = OPW'(RW'(radius) << FRAC_BITS);
      S_SQ_D:  mul_a = dy_abs[OPW-1:0];
      S_CHECK: mul_a = OPW'(f_s);
      default: mul_a = '0;
    endcase
  end
  assign mul_p = mul_a * mul_a;

  // radicand, clamped at zero
  logic [CW-1:0] c_n;
  assign c_n = (mul_p > PW'(rs2_q)) ? '0 : (rs2_q - mul_p[CW-1:0]);

  ctpg_isqrt #(.RW(RW)) u_sqrt (
    .clk_i, .rst_ni,
    .start_i(state_q == S_SQ_D),
    .radicand_i(c_n),
    .done_o(sq_done),
    .root_o(sq_root)
  );

  // pixel column and row
  logic                 exact, plus;
  logic signed [XW-1:0] h_w, f_w, x_w, y_w;
  logic signed [ROW_W-1:0] row_adj;
  assign exact   = (mul_p == PW'(c_q));
  assign plus    = !(seg_q == SEG_BACK_CENTER || seg_q == SEG_TO_TOP);
  assign h_w     = $signed(XW'(center_x));
  assign f_w     = $signed(XW'(f_c));
  assign row_adj = row_q + (row_q[ROW_W-1] ? ROW_W'((1 << FRAC_BITS) - 1) : ROW_W'(0));
  assign y_w     = XW'(row_adj >>> FRAC_BITS);

  always_comb begin
    if (plus) begin
      x_w = h_w + f_w;
    end else if (exact || (XW'(center_x) <= XW'(f_c))) begin
      x_w = h_w - f_w;
    end else begin
      x_w = h_w - f_w - XW'(1);
    end
  end

  // segment end test
  logic signed [ROW_W-1:0] target;
  logic                    up, reached;
  always_comb begin
    case (seg_q)
      SEG_TO_CENTER:   begin target = k_s;   up = 1'b1; end
      SEG_TO_BOTTOM:   begin target = kpr_s; up = 1'b1; end
      SEG_BACK_CENTER: begin target = k_s;   up = 1'b0; end
      SEG_TO_TOP:      begin target = kmr_s; up = 1'b0; end
      default:         begin target = sy_s;  up = 1'b1; end
    endcase
  end
  assign reached = up ? (row_q >= target) : (row_q <= target);

  // sequencer: next state and trace state
  always_comb begin
    state_d  = state_q;
    active_d = active_q;
    seg_d    = seg_q;
    row_d    = row_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (restart_i) begin
            active_d = quad;
            seg_d    = SEG_TO_CENTER;
            row_d    = sy_s;
          end
          state_d = (restart_i ? quad : active_q) ? S_SQ_R : S_DONE;
        end
      end
      S_SQ_R:  state_d = S_SQ_D;
      S_SQ_D:  state_d = S_ROOT;
      S_ROOT:  if (sq_done) state_d = S_CHECK;
      S_CHECK: begin
        state_d = S_DONE;
        if (reached) begin
          if (seg_q == SEG_TO_START) begin
            active_d = 1'b0;
            seg_d    = SEG_TO_CENTER;
          end else begin
            seg_d = seg_e'(seg_q + 3'd1);
          end
        end else begin
          row_d = up ? row_q + ROW_W'(1) : row_q - ROW_W'(1);
        end
      end
      S_DONE:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      active_q <= 1'b0;
      seg_q    <= SEG_TO_CENTER;
      row_q    <= '0;
    end else begin
      state_q  <= state_d;
      active_q <= active_d;
      seg_q    <= seg_d;
      row_q    <= row_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        res_x_q    <= '0;
        res_y_q    <= '0;
        res_last_q <= 1'b0;
        res_idle_q <= 1'b1;
      end
      S_SQ_R: rs2_q <= mul_p[CW-1:0];
      S_SQ_D: c_q   <= c_n;
      S_ROOT: if (sq_done) root_q <= sq_root;
      S_CHECK: begin
        res_x_q    <= x_w[OUT_W-1:0];
        res_y_q    <= y_w[OUT_W-1:0];
        res_last_q <= reached && (seg_q == SEG_TO_START);
        res_idle_q <= 1'b0;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && out_free) begin
      pixel_x_q <= res_x_q;
      pixel_y_q <= res_y_q;
      colour_q  <= res_idle_q ? '0 : pen_colour;
      last_q    <= res_last_q;
      idle_q    <= res_idle_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_x_o   = pixel_x_q;
  assign pixel_y_o   = pixel_y_q;
  assign colour_o    = colour_q;
  assign last_o      = last_q;
  assign idle_o      = idle_q;

  // checks
  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && idle_o |-> pixel_x_o == '0 && pixel_y_o == '0 && colour_o == '0 && !last_o)
    else $error("idle word carries pixel data");

  a_last_not_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> !idle_o)
    else $error("last pixel marked idle");

  a_seg_when_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_q |-> seg_q == SEG_TO_CENTER)
    else $error("segment left over with no trace running");

  a_root_only_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SQ_R |-> active_q)
    else $error("root started with no trace running");

endmodule
